// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KDH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define KDH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/kdh_pkg.sv =====
// Types, constants and helpers of the key debounce, hold and multi-click unit.
package kdh_pkg;

    localparam int NUM_KEYS    = 5;
    localparam int COUNT_WIDTH = 16;
    localparam int CFG_W       = 16;
    localparam int CLICK_W     = 4;
    localparam int KEY_W       = 3;
    localparam int KEY_AW      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CLICK_W-1:0] CLICKS_MIN = CLICK_W'(1);
    localparam logic [CLICK_W-1:0] CLICKS_MAX = CLICK_W'(14);
    localparam logic [CLICK_W-1:0] RUN_IDLE   = CLICK_W'(1);
    localparam logic [CLICK_W-1:0] RUN_SINGLE = CLICK_W'(2);

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [CFG_W-1:0]       cfg_word_t;

    localparam count_t CNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        ST_RELEASED = 2'd0,
        ST_PRESSED  = 2'd1,
        ST_HELD     = 2'd2
    } key_state_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PRESS   = 3'd1,
        EV_RELEASE = 3'd2,
        EV_HOLD    = 3'd3,
        EV_CLICKS  = 3'd4
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_HOLD       = 2'd1,
        CFG_GAP        = 2'd2,
        CFG_MAX_CLICKS = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        key_state_t           state;
        count_t               press_ticks;
        count_t               release_ticks;
        logic [CLICK_W-1:0]   click_run;
        count_t               gap_ticks;
    } key_entry_t;

    localparam key_entry_t ENTRY_RESET = '{
        state:         ST_RELEASED,
        press_ticks:   '0,
        release_ticks: '0,
        click_run:     RUN_IDLE,
        gap_ticks:     '0
    };

    function automatic count_t sat_inc(input count_t v);
        return (v == CNT_MAX) ? v : v + count_t'(1);
    endfunction

    function automatic logic cnt_ge(input count_t c, input cfg_word_t t);
        return 33'(c) >= 33'(t);
    endfunction

    function automatic logic cnt_gt(input count_t c, input cfg_word_t t);
        return 33'(c) > 33'(t);
    endfunction

endpackage

// ===== sv/key_debounce_hold_multiclick_unit.sv =====
// Top level of the key debounce, hold and multi-click unit.
//
// Usage: each beat on the s_ channel is one scan tick of one key (key index
// and sampled level). Every accepted beat yields exactly one beat on the m_
// channel carrying an event code and, for an ended click run, the click count.
// Indices at or above the key count yield event none and touch no state.
// Path: an accepted input beat enters the update stage as its key state RAM
// read is registered; the update logic then loads the output register.
// Throughput: one beat per cycle while m_tready is high. Key state is read
// from a RAM as a beat enters the update stage and written back as it leaves;
// a bypass register forwards the last written entry to a repeat of its key.
// Configuration: cfg_ beats write a register by index; always ready. Write
// only while the unit is idle.
// Reset: config registers return to their defaults and per-key valid bits
// clear, so every key reads as released and idle; no clearing pass is needed.
// Stall: when m_tready is low the result waits in the output register, one
// more beat is taken into the update stage, then s_tready drops.
module key_debounce_hold_multiclick_unit
    import kdh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [2:0] key_index, [3] level
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [2:0] event_res, [6:3] click_count
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    // Configuration
    cfg_word_t          debounce_reg;
    cfg_word_t          hold_reg;
    cfg_word_t          gap_cfg_reg;
    logic [CLICK_W-1:0] max_clicks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= CFG_W'(2);
            hold_reg       <= CFG_W'(50);
            gap_cfg_reg    <= CFG_W'(15);
            max_clicks_reg <= CLICK_W'(3);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_DEBOUNCE:   debounce_reg   <= cfg_data;
                CFG_HOLD:       hold_reg       <= cfg_data;
                CFG_GAP:        gap_cfg_reg    <= cfg_data;
                CFG_MAX_CLICKS: max_clicks_reg <= cfg_data[CLICK_W-1:0];
                default:        ;
            endcase
        end
    end

    logic [CLICK_W-1:0] click_cap;

    always_comb
    begin
        if (max_clicks_reg < CLICKS_MIN)
        begin
            click_cap = CLICKS_MIN + CLICK_W'(1);
        end
        else if (max_clicks_reg > CLICKS_MAX)
        begin
            click_cap = CLICKS_MAX + CLICK_W'(1);
        end
        else
        begin
            click_cap = max_clicks_reg + CLICK_W'(1);
        end
    end

    // Input stage
    logic [KEY_W-1:0] in_key;
    logic             in_level;
    logic             in_key_ok;
    logic             s_accept;

    assign in_key    = s_tdata[KEY_W-1:0];
    assign in_level  = s_tdata[KEY_W];
    assign in_key_ok = ({1'b0, in_key} < (KEY_W + 1)'(NUM_KEYS));
    assign s_accept  = s_tvalid && s_tready;

    // Update stage
    logic             s1_valid_reg;
    logic [KEY_W-1:0] s1_key_reg;
    logic             s1_level_reg;
    logic             s1_ok_reg;
    logic             m_valid_reg;
    logic             advance;

    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_key_reg   <= in_key;
            s1_level_reg <= in_level;
            s1_ok_reg    <= in_key_ok;
        end
    end

    // Key state RAM with per-key valid bits and a write bypass
    localparam int ENTRY_W = $bits(key_entry_t);

    logic [ENTRY_W-1:0] rd_data;
    key_entry_t         entry_next;
    logic               wr_en;
    logic [KEY_AW-1:0]  s1_addr;

    assign s1_addr = s1_key_reg[KEY_AW-1:0];
    assign wr_en   = advance && s1_ok_reg;

    kdh_ram #(
        .DEPTH (NUM_KEYS),
        .WIDTH (ENTRY_W),
        .AW    (KEY_AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (entry_next),
        .rd_en   (s_accept && in_key_ok),
        .rd_addr (in_key[KEY_AW-1:0]),
        .rd_data (rd_data)
    );

    logic [NUM_KEYS-1:0] entry_valid_reg;
    logic                byp_valid_reg;
    logic [KEY_AW-1:0]   byp_key_reg;
    key_entry_t          byp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            byp_valid_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            entry_valid_reg[s1_addr] <= 1'b1;
            byp_valid_reg            <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byp_key_reg  <= s1_addr;
            byp_data_reg <= entry_next;
        end
    end

    key_entry_t cur;

    always_comb
    begin
        if (byp_valid_reg && (byp_key_reg == s1_addr))
        begin
            cur = byp_data_reg;
        end
        else if (entry_valid_reg[s1_addr])
        begin
            cur = key_entry_t'(rd_data);
        end
        else
        begin
            cur = ENTRY_RESET;
        end
    end

    // Per-key decisions
    count_t press_inc;
    count_t release_inc;
    logic   press_hit;
    logic   hold_hit;
    logic   release_hit;
    logic   gap_hit;

    assign press_inc   = sat_inc(cur.press_ticks);
    assign release_inc = sat_inc(cur.release_ticks);
    assign press_hit   = cnt_ge(press_inc, debounce_reg);
    assign hold_hit    = (cur.click_run == RUN_SINGLE) && cnt_ge(press_inc, hold_reg);
    assign release_hit = cnt_ge(release_inc, debounce_reg);
    assign gap_hit     = (cur.click_run != RUN_IDLE)
                         && (cnt_gt(cur.gap_ticks, gap_cfg_reg) || (cur.gap_ticks == CNT_MAX));

    always_comb
    begin
        entry_next = cur;
        case (cur.state)
            ST_PRESSED, ST_HELD:
            begin
                if (s1_level_reg)
                begin
                    entry_next.release_ticks = '0;
                    entry_next.gap_ticks     = '0;
                    if (cur.state == ST_HELD)
                    begin
                        entry_next.click_run = RUN_IDLE;
                    end
                    else if (hold_hit)
                    begin
                        entry_next.press_ticks = '0;
                        entry_next.state       = ST_HELD;
                    end
                    else
                    begin
                        entry_next.press_ticks = press_inc;
                    end
                end
                else if (release_hit)
                begin
                    entry_next.release_ticks = '0;
                    entry_next.state         = ST_RELEASED;
                end
                else
                begin
                    entry_next.release_ticks = release_inc;
                end
            end
            default:
            begin
                if (s1_level_reg)
                begin
                    if (press_hit)
                    begin
                        entry_next.press_ticks = '0;
                        entry_next.state       = ST_PRESSED;
                        if (cur.click_run == RUN_IDLE)
                        begin
                            entry_next.click_run = RUN_SINGLE;
                        end
                        else if (cur.click_run < click_cap)
                        begin
                            entry_next.click_run = cur.click_run + CLICK_W'(1);
                            entry_next.gap_ticks = '0;
                        end
                    end
                    else
                    begin
                        entry_next.press_ticks = press_inc;
                    end
                end
                else
                begin
                    entry_next.press_ticks = '0;
                    if (gap_hit)
                    begin
                        entry_next.gap_ticks = '0;
                        entry_next.click_run = RUN_IDLE;
                    end
                    else if (cur.click_run != RUN_IDLE)
                    begin
                        entry_next.gap_ticks = sat_inc(cur.gap_ticks);
                    end
                end
            end
        endcase
    end

    event_t             ev_next;
    logic [CLICK_W-1:0] count_next;

    always_comb
    begin
        ev_next = EV_NONE;
        if (s1_ok_reg)
        begin
            case (cur.state)
                ST_PRESSED, ST_HELD:
                begin
                    if (s1_level_reg)
                    begin
                        if ((cur.state == ST_HELD) || hold_hit)
                        begin
                            ev_next = EV_HOLD;
                        end
                    end
                    else if (release_hit)
                    begin
                        ev_next = EV_RELEASE;
                    end
                end
                default:
                begin
                    if (s1_level_reg)
                    begin
                        if (press_hit && (cur.click_run == RUN_IDLE))
                        begin
                            ev_next = EV_PRESS;
                        end
                    end
                    else if (gap_hit)
                    begin
                        ev_next = EV_CLICKS;
                    end
                end
            endcase
        end
        count_next = (ev_next == EV_CLICKS) ? (cur.click_run - CLICK_W'(1)) : '0;
    end

    // Output register
    event_t             m_event_reg;
    logic [CLICK_W-1:0] m_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_event_reg <= ev_next;
            m_count_reg <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({m_count_reg, m_event_reg});

endmodule

// ===== sv/kdh_ram.sv =====
// Simple dual-port key state RAM, one write and one registered read port.
module kdh_ram #(
    parameter int DEPTH = 5,
    parameter int WIDTH = 8,
    parameter int AW    = 3
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/kdh_checker.sv =====
// Port-level checker for the key debounce, hold and multi-click unit, with its bind.
`include "assert_macros.svh"

module kdh_checker
    import kdh_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   cfg_valid,
    input logic                   cfg_ready
);

    logic               out_is_clicks;
    logic [CLICK_W-1:0] out_count;

    assign out_is_clicks = (m_tdata[2:0] == EV_CLICKS);
    assign out_count     = m_tdata[6:3];

    `KDH_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")
    `KDH_ASSERT_IMP(a_count_zero, clk, rst_n, m_tvalid && !out_is_clicks, out_count == '0, "click count set on a non-click event")
    `KDH_ASSERT_IMP(a_count_range, clk, rst_n, m_tvalid && out_is_clicks, (out_count != '0) && (out_count <= CLICKS_MAX), "ended click run count out of range")
    `KDH_ASSERT_IMP(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready, "configuration write not taken")

endmodule

bind key_debounce_hold_multiclick_unit kdh_checker u_kdh_checker (.*);

// ===== verif/tb_key_debounce_hold_multiclick_unit.sv =====
// Testbench for the key debounce, hold and multi-click unit: scoreboard against an in-line model.
module tb_key_debounce_hold_multiclick_unit;
    import kdh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_SLACK    = 8;
    localparam int LEN_CLIP       = 24;

    typedef struct {
        event_t             ev;
        logic [CLICK_W-1:0] cnt;
    } key_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // [2:0] key_index, [3] level
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // [2:0] event_res, [6:3] click_count
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    key_debounce_hold_multiclick_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // shadow copy of the per-key state and registers
    key_state_t         key_phase   [NUM_KEYS];
    count_t             press_run   [NUM_KEYS];
    count_t             release_run [NUM_KEYS];
    logic [CLICK_W-1:0] click_tally [NUM_KEYS];
    count_t             quiet_ticks [NUM_KEYS];
    cfg_word_t          debounce_thr;
    cfg_word_t          hold_thr;
    cfg_word_t          gap_thr;
    logic [CLICK_W-1:0] clicks_cfg;

    key_result_t expected_events[$];
    int          mismatches;
    int          scans_sent;
    int          results_seen;
    int          ev_tally [5];
    int          idle_cycles;
    int          stall_left;
    bit          calm_mode;

    function automatic count_t bump(input count_t v);
        return v + count_t'(v != CNT_MAX);
    endfunction

    function automatic int clip(input cfg_word_t v);
        return (v > LEN_CLIP) ? LEN_CLIP : int'(v);
    endfunction

    function automatic key_result_t advance_key(input logic [KEY_W-1:0] key, input logic lvl);
        key_result_t        r;
        count_t             prev_gap;
        logic [CLICK_W-1:0] lim;
        r.ev  = EV_NONE;
        r.cnt = '0;
        if (key >= NUM_KEYS)
            return r;
        lim = (clicks_cfg < CLICKS_MIN) ? CLICKS_MIN :
              (clicks_cfg > CLICKS_MAX) ? CLICKS_MAX : clicks_cfg;
        if (key_phase[key] != ST_RELEASED)
        begin
            if (lvl)
            begin
                release_run[key] = '0;
                quiet_ticks[key] = '0;
                if (key_phase[key] == ST_HELD)
                begin
                    click_tally[key] = RUN_IDLE;
                    r.ev = EV_HOLD;
                end
                else
                begin
                    press_run[key] = bump(press_run[key]);
                    if (click_tally[key] == RUN_SINGLE && press_run[key] >= hold_thr)
                    begin
                        press_run[key] = '0;
                        key_phase[key] = ST_HELD;
                        r.ev = EV_HOLD;
                    end
                end
            end
            else
            begin
                release_run[key] = bump(release_run[key]);
                if (release_run[key] >= debounce_thr)
                begin
                    key_phase[key]   = ST_RELEASED;
                    release_run[key] = '0;
                    r.ev = EV_RELEASE;
                end
            end
        end
        else if (lvl)
        begin
            press_run[key] = bump(press_run[key]);
            if (press_run[key] >= debounce_thr)
            begin
                key_phase[key] = ST_PRESSED;
                press_run[key] = '0;
                if (click_tally[key] == RUN_IDLE)
                begin
                    click_tally[key] = RUN_SINGLE;
                    r.ev = EV_PRESS;
                end
                else if (click_tally[key] < lim + 1)
                begin
                    click_tally[key] = click_tally[key] + 1'b1;
                    quiet_ticks[key] = '0;
                end
            end
        end
        else
        begin
            press_run[key] = '0;
            if (click_tally[key] != RUN_IDLE)
            begin
                prev_gap         = quiet_ticks[key];
                quiet_ticks[key] = bump(prev_gap);
                // run closes once the gap is exceeded, or when the gap count is pinned
                if (prev_gap > gap_thr || prev_gap == CNT_MAX)
                begin
                    r.ev  = EV_CLICKS;
                    r.cnt = click_tally[key] - 1'b1;
                    quiet_ticks[key] = '0;
                    click_tally[key] = RUN_IDLE;
                end
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        if (mismatches < 25)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_scan(input logic [KEY_W-1:0] key, input logic lvl);
        int gap;
        gap = (!calm_mode && $urandom_range(99) < 12) ? $urandom_range(1, 3) : 0;
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {4'b0000, 4'($urandom)};
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, lvl, key};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        expected_events.push_back(advance_key(key, lvl));
        if (key < NUM_KEYS)
            scans_sent++;
        @(negedge clk);
    endtask

    task automatic send_run(input logic [KEY_W-1:0] key, input logic lvl, input int len,
                            input bit noisy);
        for (int i = 0; i < len; i++)
        begin
            if (noisy && $urandom_range(99) < 15)
                send_scan(KEY_W'($urandom_range(7)), 1'($urandom_range(1)));
            send_scan(key, lvl);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_events.size() != 0)
            @(negedge clk);
        repeat (DRAIN_SLACK) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input cfg_word_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            CFG_DEBOUNCE:   debounce_thr = val;
            CFG_HOLD:       hold_thr     = val;
            CFG_GAP:        gap_thr      = val;
            CFG_MAX_CLICKS: clicks_cfg   = val[CLICK_W-1:0];
            default:        ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic play_episode();
        logic [KEY_W-1:0] key;
        int               db;
        int               hd;
        int               gp;
        int               n;
        db  = clip(debounce_thr);
        hd  = clip(hold_thr);
        gp  = clip(gap_thr);
        key = KEY_W'($urandom_range(NUM_KEYS - 1));
        if ($urandom_range(9) == 0)
        begin
            send_scan(KEY_W'($urandom_range(7, NUM_KEYS)), 1'($urandom_range(1)));
            return;
        end
        case ($urandom_range(3))
            0:
            begin
                n = (db > 4) ? $urandom_range(1, 3) : $urandom_range(1, 15);
                repeat (n)
                begin
                    send_run(key, 1'b1, db + $urandom_range(1), 1'b1);
                    send_run(key, 1'b0, db + $urandom_range(1), 1'b1);
                end
                send_run(key, 1'b0, gp + $urandom_range(3), 1'b1);
            end
            1:
            begin
                send_run(key, 1'b1, db + hd + $urandom_range(3), 1'b1);
                send_run(key, 1'b0, db + $urandom_range(2), 1'b1);
            end
            2:
                repeat ($urandom_range(1, 4))
                    send_run(key, 1'($urandom_range(1)), $urandom_range(1, db), 1'b1);
            default:
            begin
                send_run(key, 1'b1, db, 1'b1);
                send_run(key, 1'b0, db + $urandom_range(gp + 2), 1'b1);
            end
        endcase
    endtask

    task automatic random_scans(input int n);
        int start;
        start = scans_sent;
        while (scans_sent - start < n)
            play_episode();
    endtask

    task automatic test_reset_defaults();
        random_scans(120);
    endtask

    task automatic test_threshold_extremes();
        logic [3:0] seq [$];
        // {level, key}: hold on a single press, lone click, silent re-press then hold, bad keys
        seq = '{4'h8, 4'h8, 4'h8, 4'h0, 4'h0,
                4'hC, 4'h4, 4'h4, 4'h4,
                4'h9, 4'h1, 4'h9, 4'h9, 4'h1, 4'h1, 4'h1,
                4'hD, 4'h6, 4'hF, 4'h7};
        drain_results();
        write_reg(CFG_DEBOUNCE, 16'd1);
        write_reg(CFG_HOLD, 16'd1);
        write_reg(CFG_GAP, 16'd0);
        write_reg(CFG_MAX_CLICKS, 16'd1);
        foreach (seq[i])
            send_scan(seq[i][2:0], seq[i][3]);
    endtask

    task automatic test_click_cap();
        drain_results();
        calm_mode = 1'b1;
        write_reg(CFG_HOLD, 16'd6);
        write_reg(CFG_GAP, 16'd3);
        write_reg(CFG_MAX_CLICKS, 16'd14);
        random_scans(100);
        drain_results();
        write_reg(CFG_MAX_CLICKS, 16'd15);
        random_scans(80);
        calm_mode = 1'b0;
    endtask

    task automatic test_low_cap();
        drain_results();
        write_reg(CFG_DEBOUNCE, 16'd2);
        write_reg(CFG_HOLD, 16'd4);
        write_reg(CFG_GAP, 16'd1);
        write_reg(CFG_MAX_CLICKS, 16'd0);
        random_scans(120);
    endtask

    task automatic test_large_thresholds();
        drain_results();
        write_reg(CFG_DEBOUNCE, 16'd3);
        write_reg(CFG_HOLD, CNT_MAX);
        write_reg(CFG_GAP, CNT_MAX);
        random_scans(60);
        drain_results();
        write_reg(CFG_DEBOUNCE, CNT_MAX);
        random_scans(20);
    endtask

    task automatic test_output_backpressure();
        drain_results();
        write_reg(CFG_DEBOUNCE, 16'd2);
        write_reg(CFG_HOLD, 16'd5);
        write_reg(CFG_GAP, 16'd2);
        write_reg(CFG_MAX_CLICKS, 16'd5);
        stall_left = 150;
        random_scans(120);
    endtask

    always @(posedge clk)
    begin
        key_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_events.size() == 0)
                note_mismatch($sformatf("result with nothing pending: event %0d count %0d",
                                        m_tdata[2:0], m_tdata[6:3]));
            else
            begin
                exp_r = expected_events.pop_front();
                if (m_tdata[2:0] !== exp_r.ev)
                    note_mismatch($sformatf("event %0d, want %s", m_tdata[2:0], exp_r.ev.name()));
                if (m_tdata[6:3] !== exp_r.cnt)
                    note_mismatch($sformatf("click count %0d, want %0d", m_tdata[6:3], exp_r.cnt));
                results_seen++;
                ev_tally[int'(exp_r.ev)]++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles", idle_cycles);
            $display("** key_debounce_hold_multiclick_unit: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= calm_mode || ($urandom_range(99) >= 24);
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_DEBOUNCE;
        cfg_data     = '0;
        idle_cycles  = 0;
        debounce_thr = 16'd2;
        hold_thr     = 16'd50;
        gap_thr      = 16'd15;
        clicks_cfg   = 4'd3;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            key_phase[k]   = ST_RELEASED;
            press_run[k]   = '0;
            release_run[k] = '0;
            click_tally[k] = RUN_IDLE;
            quiet_ticks[k] = '0;
        end
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_threshold_extremes();
        test_click_cap();
        test_low_cap();
        test_large_thresholds();
        test_output_backpressure();
        drain_results();

        $display("%0d scans, %0d results checked: press %0d, release %0d, hold %0d, run end %0d",
                 scans_sent, results_seen, ev_tally[EV_PRESS], ev_tally[EV_RELEASE],
                 ev_tally[EV_HOLD], ev_tally[EV_CLICKS]);
        $display("reset defaults, threshold extremes, click cap clamping, stalls, top thresholds");
        if (mismatches == 0)
            $display("** key_debounce_hold_multiclick_unit: PASSED **");
        else
            $display("** key_debounce_hold_multiclick_unit: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/kdh_pkg.sv
sv/kdh_ram.sv
sv/key_debounce_hold_multiclick_unit.sv
sv/kdh_checker.sv
verif/tb_key_debounce_hold_multiclick_unit.sv
